>>> design/prap_pkg.sv
// Shared types, constants and register codes for the pitch/roll attitude PID block.
package prap_pkg;

  // Field widths.
  localparam int PULSE_W = 12;
  localparam int ANGLE_W = 16;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int DRIVE_W = 16;

  // Axis numbering used by the per-axis arrays.
  localparam int AXES       = 2;
  localparam int AXIS_ROLL  = 0;
  localparam int AXIS_PITCH = 1;

  // Radio deadband.
  localparam logic [PULSE_W-1:0] DB_LOW    = 12'd1460;
  localparam logic [PULSE_W-1:0] DB_HIGH   = 12'd1500;
  localparam logic [PULSE_W-1:0] DB_CENTER = 12'd1478;

  // Setpoint mapping: 90 degrees of span and 45 degrees of offset, in Q8.8.
  localparam int SP_SCALE = 90 * 256;
  localparam int SP_HALF  = 45 * 256;

  // Setpoint datapath widths; the scaled pulse stays below 2**M_W.
  localparam int M_W         = 27;
  localparam int RECIP_SHIFT = 28;
  localparam int R_W         = 29;
  localparam int SP_RAW_W    = M_W + 2;
  localparam int SP_W        = 16;

  // PID datapath widths.
  localparam int ERR_W      = 17;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int SUM_W      = LIM_W + 8 + 1;
  localparam int TOT_W      = 42;
  localparam int FRAC_SHIFT = 16;
  localparam int ROUND_HALF = 32768;

  // Queues and pipeline depths.
  localparam int QUEUE_DEPTH  = 8;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FRONT_STAGES = 5;
  localparam int BACK_STAGES  = 3;

  // Configuration register indexes.
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_PITCH_P_GAIN = 3'd0;
  localparam logic [IDX_W-1:0] REG_PITCH_I_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_PITCH_D_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROLL_P_GAIN  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROLL_I_GAIN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROLL_D_GAIN  = 3'd5;
  localparam logic [IDX_W-1:0] REG_PITCH_LIMIT  = 3'd6;
  localparam logic [IDX_W-1:0] REG_ROLL_LIMIT   = 3'd7;

  // Input transaction.
  typedef struct packed {
    logic                      mode;
    logic [PULSE_W-1:0]        roll_pulse;
    logic [PULSE_W-1:0]        pitch_pulse;
    logic [PULSE_W-1:0]        yaw_pulse;
    logic signed [ANGLE_W-1:0] measured_pitch;
    logic signed [ANGLE_W-1:0] measured_roll;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic signed [DRIVE_W-1:0] pitch_drive;
    logic signed [DRIVE_W-1:0] roll_drive;
    logic [PULSE_W-1:0]        roll_pulse_out;
    logic [PULSE_W-1:0]        pitch_pulse_out;
    logic [PULSE_W-1:0]        yaw_pulse_out;
  } out_item_t;

  // Classified transaction handed from the front to the back.
  typedef struct packed {
    logic                    mode;
    logic [PULSE_W-1:0]      roll_pulse;
    logic [PULSE_W-1:0]      pitch_pulse;
    logic [PULSE_W-1:0]      yaw_pulse;
    logic signed [ERR_W-1:0] pitch_err;
    logic signed [ERR_W-1:0] roll_err;
  } mid_item_t;

  // Configuration register file.
  typedef struct packed {
    logic [GAIN_W-1:0] pitch_p_gain;
    logic [GAIN_W-1:0] pitch_i_gain;
    logic [GAIN_W-1:0] pitch_d_gain;
    logic [GAIN_W-1:0] roll_p_gain;
    logic [GAIN_W-1:0] roll_i_gain;
    logic [GAIN_W-1:0] roll_d_gain;
    logic [LIM_W-1:0]  pitch_limit;
    logic [LIM_W-1:0]  roll_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pitch_p_gain: 16'd256,
    pitch_i_gain: 16'd0,
    pitch_d_gain: 16'd0,
    roll_p_gain:  16'd256,
    roll_i_gain:  16'd0,
    roll_d_gain:  16'd0,
    pitch_limit:  15'd400,
    roll_limit:   15'd400
  };

endpackage

>>> design/pitch_roll_attitude_pid.sv
// Top level of the dual-axis pitch/roll attitude PID controller.
//
// Usage: samples enter through a queue-like port. A sample is taken at a rising
// edge with push high and full low. Each sample gives exactly one result, which
// waits on the result port while empty is low and leaves at an edge with pop high.
// Mode 1 clears both error sums and last errors and returns zero drives; the
// snapped pulses are returned in both modes.
// Pipeline: a result is registered through five front stages (snap, reciprocal
// multiply, quotient correction, clamp, error), the hand-off queue and three
// back stages (integrator, products, round and clamp).
// Throughput: one sample per cycle while full stays low. The integrator update
// is a registered loop within back stage 1, and all other work is pipelined.
// Stalls: results collect in an 8-entry result queue; when it cannot absorb
// what is in flight the back end holds, the 8-entry hand-off queue fills and
// full rises. No transaction is dropped.
// Reset (synchronous, rst high) empties both queues and pipelines, clears the
// controller state and loads the default gains and limits. Configuration writes
// take effect at once and must be made while no sample is in flight; not enforced.
module pitch_roll_attitude_pid #(
  parameter int RADIO_LOW       = 1000,
  parameter int RADIO_HIGH      = 1956,
  parameter int PITCH_MAX_ANGLE = 30,
  parameter int ROLL_MAX_ANGLE  = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  prap_pkg::in_item_t          sample,
  output logic                        empty,
  input  logic                        pop,
  output prap_pkg::out_item_t         result,
  input  logic                        cfg_write,
  input  logic [prap_pkg::IDX_W-1:0]  cfg_index,
  input  logic [prap_pkg::GAIN_W-1:0] cfg_data
);

  import prap_pkg::*;

  localparam int MID_W = $bits(mid_item_t);
  localparam int OUT_W = $bits(out_item_t);

  cfg_t               cfg;
  logic               mid_push;
  mid_item_t          mid_in;
  logic [MID_W-1:0]   mid_rdata;
  logic               mid_empty;
  logic               mid_pop;
  logic [QCNT_W-1:0]  mid_count;
  logic               out_push;
  out_item_t          out_in;
  logic [OUT_W-1:0]   out_rdata;
  logic [QCNT_W-1:0]  out_count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PITCH_P_GAIN: cfg.pitch_p_gain <= cfg_data;
        REG_PITCH_I_GAIN: cfg.pitch_i_gain <= cfg_data;
        REG_PITCH_D_GAIN: cfg.pitch_d_gain <= cfg_data;
        REG_ROLL_P_GAIN:  cfg.roll_p_gain  <= cfg_data;
        REG_ROLL_I_GAIN:  cfg.roll_i_gain  <= cfg_data;
        REG_ROLL_D_GAIN:  cfg.roll_d_gain  <= cfg_data;
        REG_PITCH_LIMIT:  cfg.pitch_limit  <= LIM_W'(cfg_data);
        REG_ROLL_LIMIT:   cfg.roll_limit   <= LIM_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Front end.
  prap_front #(
    .RADIO_LOW       (RADIO_LOW),
    .RADIO_HIGH      (RADIO_HIGH),
    .PITCH_MAX_ANGLE (PITCH_MAX_ANGLE),
    .ROLL_MAX_ANGLE  (ROLL_MAX_ANGLE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .sample    (sample),
    .mid_count (mid_count),
    .full      (full),
    .mid_push  (mid_push),
    .mid_item  (mid_in)
  );

  // Hand-off queue between front and back.
  prap_queue #(
    .WIDTH (MID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (MID_W'(mid_in)),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  // Back end.
  prap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .mid_item  (mid_item_t'(mid_rdata)),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_item  (out_in)
  );

  // Result queue.
  prap_queue #(
    .WIDTH (OUT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (OUT_W'(out_in)),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign result = out_item_t'(out_rdata);

endmodule

>>> design/prap_queue.sv
// Small register-based FIFO used between the front, the back and the result port.
module prap_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    head;
  logic [AW-1:0]    tail;
  logic             do_pop;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
    if (ptr == AW'(DEPTH - 1)) begin
      return '0;
    end
    return ptr + AW'(1);
  endfunction

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign rdata  = slots[head];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= wrap_inc(tail);
      end
      if (do_pop) begin
        head <= wrap_inc(head);
      end
      if (push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= wdata;
    end
  end

endmodule

>>> design/prap_front.sv
// Front end: pulse deadband snapping, setpoint mapping and per-axis error.
module prap_front #(
  parameter int RADIO_LOW       = 1000,
  parameter int RADIO_HIGH      = 1956,
  parameter int PITCH_MAX_ANGLE = 30,
  parameter int ROLL_MAX_ANGLE  = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  prap_pkg::in_item_t          sample,
  input  logic [prap_pkg::QCNT_W-1:0] mid_count,
  output logic                        full,
  output logic                        mid_push,
  output prap_pkg::mid_item_t         mid_item
);

  import prap_pkg::*;

  // Constant division by the radio span is a reciprocal multiply plus one correction.
  // The bias C_OFF keeps the dividend non-negative so the quotient is a floor.
  localparam longint SPAN     = longint'(RADIO_HIGH) - longint'(RADIO_LOW);
  localparam bit     SPAN_OK  = (SPAN > 0);
  localparam longint SPAN_EFF = SPAN_OK ? SPAN : 64'sd1;
  localparam longint LOW_SC   = longint'(RADIO_LOW) * longint'(SP_SCALE);
  localparam longint K_BIAS   = (LOW_SC + SPAN_EFF - 1) / SPAN_EFF;
  localparam longint C_OFF    = K_BIAS * SPAN_EFF - LOW_SC;
  localparam longint RECIP    = (64'sd1 <<< RECIP_SHIFT) / SPAN_EFF;
  localparam longint OFFSET   = K_BIAS + longint'(SP_HALF);
  localparam longint ROLL_MAX  = longint'(ROLL_MAX_ANGLE) * 256;
  localparam longint PITCH_MAX = longint'(PITCH_MAX_ANGLE) * 256;
  localparam int     PROD_W   = M_W + R_W;

  logic [FRONT_STAGES-1:0] valid;
  logic                    accept;
  logic [QCNT_W:0]         inflight;
  in_item_t                snapped;

  in_item_t s1, s2, s3, s4, s5;
  logic [M_W-1:0]            m_s1  [AXES];
  logic [M_W-1:0]            m_s2  [AXES];
  logic [M_W-1:0]            q0_s2 [AXES];
  logic [M_W-1:0]            q_s3  [AXES];
  logic signed [SP_W-1:0]    sp_s4 [AXES];
  logic signed [ERR_W-1:0]   err_s5[AXES];

  logic [M_W-1:0]            m_next  [AXES];
  logic [M_W-1:0]            q0_next [AXES];
  logic [M_W-1:0]            q_next  [AXES];
  logic signed [SP_W-1:0]    sp_next [AXES];
  logic signed [ERR_W-1:0]   err_next[AXES];

  function automatic logic [PULSE_W-1:0] snap(input logic [PULSE_W-1:0] p);
    if (p > DB_LOW && p < DB_HIGH) begin
      return DB_CENTER;
    end
    return p;
  endfunction

  // Admission: room must remain in the hand-off queue for everything in flight.
  always_comb begin
    inflight = (QCNT_W+1)'(mid_count);
    for (int i = 0; i < FRONT_STAGES; i++) begin
      inflight = inflight + (QCNT_W+1)'(valid[i]);
    end
  end

  assign full   = (inflight >= (QCNT_W+1)'(QUEUE_DEPTH));
  assign accept = push && !full;

  // Stage 1: snap the pulses and scale the roll and pitch pulses.
  always_comb begin
    snapped             = sample;
    snapped.roll_pulse  = snap(sample.roll_pulse);
    snapped.pitch_pulse = snap(sample.pitch_pulse);
    snapped.yaw_pulse   = snap(sample.yaw_pulse);
    m_next[AXIS_ROLL]   = M_W'(snapped.roll_pulse) * M_W'(SP_SCALE) + M_W'(C_OFF);
    m_next[AXIS_PITCH]  = M_W'(snapped.pitch_pulse) * M_W'(SP_SCALE) + M_W'(C_OFF);
  end

  // Stage 2: reciprocal multiply gives a quotient estimate at most one low.
  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int a = 0; a < AXES; a++) begin
      prod       = PROD_W'(m_s1[a]) * PROD_W'(RECIP);
      q0_next[a] = M_W'(prod >> RECIP_SHIFT);
    end
  end

  // Stage 3: correct the quotient from the remainder.
  always_comb begin
    logic [M_W-1:0] rem;
    for (int a = 0; a < AXES; a++) begin
      rem = m_s2[a] - q0_s2[a] * M_W'(SPAN_EFF);
      if (rem >= M_W'(SPAN_EFF)) begin
        q_next[a] = q0_s2[a] + M_W'(1);
      end else begin
        q_next[a] = q0_s2[a];
      end
    end
  end

  // Stage 4: remove the bias and center, then clamp to the maximum angle.
  always_comb begin
    logic signed [SP_RAW_W-1:0] sp_raw;
    logic signed [SP_RAW_W-1:0] lim;
    for (int a = 0; a < AXES; a++) begin
      sp_raw = $signed({2'b00, q_s3[a]}) - $signed(SP_RAW_W'(OFFSET));
      lim    = $signed(SP_RAW_W'((a == AXIS_ROLL) ? ROLL_MAX : PITCH_MAX));
      if (!SPAN_OK) begin
        sp_next[a] = '0;
      end else if (sp_raw > lim) begin
        sp_next[a] = SP_W'(lim);
      end else if (sp_raw < -lim) begin
        sp_next[a] = SP_W'(-lim);
      end else begin
        sp_next[a] = SP_W'(sp_raw);
      end
    end
  end

  // Stage 5: error is measured angle minus setpoint.
  always_comb begin
    err_next[AXIS_ROLL]  = ERR_W'(s4.measured_roll) - ERR_W'(sp_s4[AXIS_ROLL]);
    err_next[AXIS_PITCH] = ERR_W'(s4.measured_pitch) - ERR_W'(sp_s4[AXIS_PITCH]);
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[FRONT_STAGES-2:0], accept};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    s1 <= snapped;
    s2 <= s1;
    s3 <= s2;
    s4 <= s3;
    s5 <= s4;
    for (int a = 0; a < AXES; a++) begin
      m_s1[a]   <= m_next[a];
      m_s2[a]   <= m_s1[a];
      q0_s2[a]  <= q0_next[a];
      q_s3[a]   <= q_next[a];
      sp_s4[a]  <= sp_next[a];
      err_s5[a] <= err_next[a];
    end
  end

  // Hand-off to the back end.
  assign mid_push = valid[FRONT_STAGES-1];

  always_comb begin
    mid_item.mode        = s5.mode;
    mid_item.roll_pulse  = s5.roll_pulse;
    mid_item.pitch_pulse = s5.pitch_pulse;
    mid_item.yaw_pulse   = s5.yaw_pulse;
    mid_item.pitch_err   = err_s5[AXIS_PITCH];
    mid_item.roll_err    = err_s5[AXIS_ROLL];
  end

endmodule

>>> design/prap_back.sv
// Back end: integrator and last-error state, PID products, rounding and output clamp.
module prap_back (
  input  logic                        clk,
  input  logic                        rst,
  input  prap_pkg::cfg_t              cfg,
  input  logic                        mid_empty,
  input  prap_pkg::mid_item_t         mid_item,
  output logic                        mid_pop,
  input  logic [prap_pkg::QCNT_W-1:0] out_count,
  output logic                        out_push,
  output prap_pkg::out_item_t         out_item
);

  import prap_pkg::*;

  localparam int Q_W = TOT_W - FRAC_SHIFT;

  logic [BACK_STAGES-1:0] valid;
  logic [QCNT_W:0]        occupied;

  logic [GAIN_W-1:0] kp [AXES];
  logic [GAIN_W-1:0] ki [AXES];
  logic [GAIN_W-1:0] kd [AXES];
  logic [LIM_W-1:0]  lim[AXES];

  logic signed [ERR_W-1:0] err_in[AXES];
  logic signed [SUM_W-1:0] err_sum[AXES];
  logic signed [ERR_W-1:0] last_err[AXES];
  logic signed [SUM_W-1:0] sum_next[AXES];

  mid_item_t               b1_item, b2_item;
  logic signed [ERR_W-1:0] b1_err [AXES];
  logic signed [SUM_W-1:0] b1_sum [AXES];
  logic signed [DIFF_W-1:0] b1_diff[AXES];
  logic signed [TOT_W-1:0] p_term [AXES];
  logic signed [TOT_W-1:0] i_term [AXES];
  logic signed [TOT_W-1:0] d_term [AXES];
  logic signed [DRIVE_W-1:0] drive_next[AXES];
  out_item_t               b3_item;

  function automatic logic signed [SUM_W-1:0] clamp_sum(
    input logic signed [SUM_W-1:0] sum,
    input logic signed [ERR_W-1:0] err,
    input logic [LIM_W-1:0]        limit
  );
    logic signed [SUM_W:0] total;
    logic signed [SUM_W:0] bound;
    total = (SUM_W+1)'(sum) + (SUM_W+1)'(err);
    bound = $signed((SUM_W+1)'({limit, 8'b0}));
    if (total > bound) begin
      return SUM_W'(bound);
    end
    if (total < -bound) begin
      return SUM_W'(-bound);
    end
    return SUM_W'(total);
  endfunction

  // Per-axis view of the configuration.
  always_comb begin
    kp[AXIS_ROLL]  = cfg.roll_p_gain;
    ki[AXIS_ROLL]  = cfg.roll_i_gain;
    kd[AXIS_ROLL]  = cfg.roll_d_gain;
    lim[AXIS_ROLL] = cfg.roll_limit;
    kp[AXIS_PITCH]  = cfg.pitch_p_gain;
    ki[AXIS_PITCH]  = cfg.pitch_i_gain;
    kd[AXIS_PITCH]  = cfg.pitch_d_gain;
    lim[AXIS_PITCH] = cfg.pitch_limit;
    err_in[AXIS_ROLL]  = mid_item.roll_err;
    err_in[AXIS_PITCH] = mid_item.pitch_err;
  end

  // Take a transaction only when the result queue can hold everything in flight.
  always_comb begin
    occupied = (QCNT_W+1)'(out_count);
    for (int i = 0; i < BACK_STAGES; i++) begin
      occupied = occupied + (QCNT_W+1)'(valid[i]);
    end
  end

  assign mid_pop = !mid_empty && (occupied < (QCNT_W+1)'(QUEUE_DEPTH));

  // Stage 1: clamped error sum; with the last error, the only state carried between items.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_next[a] = clamp_sum(err_sum[a], err_in[a], lim[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        err_sum[a]  <= '0;
        last_err[a] <= '0;
      end
    end else if (mid_pop) begin
      for (int a = 0; a < AXES; a++) begin
        if (mid_item.mode) begin
          err_sum[a]  <= '0;
          last_err[a] <= '0;
        end else begin
          err_sum[a]  <= sum_next[a];
          last_err[a] <= err_in[a];
        end
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[BACK_STAGES-2:0], mid_pop};
    end
  end

  // Stage 3 combinational part: sum the terms, round half up, clamp to the limit, or zero in mode 1.
  always_comb begin
    logic signed [TOT_W-1:0] total;
    logic signed [Q_W-1:0]   q;
    logic signed [Q_W-1:0]   bound;
    for (int a = 0; a < AXES; a++) begin
      total = p_term[a] + i_term[a] + d_term[a] + TOT_W'(ROUND_HALF);
      q     = Q_W'(total >>> FRAC_SHIFT);
      bound = $signed(Q_W'(lim[a]));
      if (b2_item.mode) begin
        drive_next[a] = '0;
      end else if (q > bound) begin
        drive_next[a] = DRIVE_W'(bound);
      end else if (q < -bound) begin
        drive_next[a] = DRIVE_W'(-bound);
      end else begin
        drive_next[a] = DRIVE_W'(q);
      end
    end
  end

  // Stage payload: stage 1 captures error, sum and difference, stage 2 the products, stage 3 the result.
  always_ff @(posedge clk) begin
    b1_item <= mid_item;
    b2_item <= b1_item;
    for (int a = 0; a < AXES; a++) begin
      b1_err[a]  <= err_in[a];
      b1_sum[a]  <= sum_next[a];
      b1_diff[a] <= DIFF_W'(err_in[a]) - DIFF_W'(last_err[a]);
      p_term[a]  <= TOT_W'($signed({1'b0, kp[a]})) * TOT_W'(b1_err[a]);
      i_term[a]  <= TOT_W'($signed({1'b0, ki[a]})) * TOT_W'(b1_sum[a]);
      d_term[a]  <= TOT_W'($signed({1'b0, kd[a]})) * TOT_W'(b1_diff[a]);
    end
    b3_item.pitch_drive     <= drive_next[AXIS_PITCH];
    b3_item.roll_drive      <= drive_next[AXIS_ROLL];
    b3_item.roll_pulse_out  <= b2_item.roll_pulse;
    b3_item.pitch_pulse_out <= b2_item.pitch_pulse;
    b3_item.yaw_pulse_out   <= b2_item.yaw_pulse;
  end

  assign out_push = valid[BACK_STAGES-1];
  assign out_item = b3_item;

endmodule
